/* src/hwd_pkg.sv */
// Shared types, constants and helpers for the heartbeat watchdog core.
// Used by heartbeat_watchdog_fsm_core and its testbench; depends on nothing else.
`default_nettype none

package hwd_pkg;

    // Width of all millisecond time values; differences wrap at this width.
    localparam int TIME_W = 32;

    // Field widths of one poll and one result.
    localparam int BEAT_W  = 64;
    localparam int CODE_W  = 3;
    localparam int COUNT_W = 16;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes.
    localparam int S_BITS   = TIME_W + BEAT_W + TIME_W;
    localparam int S_DATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_BITS   = CODE_W + 1 + 3 * TIME_W + COUNT_W;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = TIME_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WATCH_ENABLE     = 3'd0,
        REG_ALARM_TIMEOUT    = 3'd1,
        REG_FAULT_TIMEOUT    = 3'd2,
        REG_RECOVERY_TIMEOUT = 3'd3,
        REG_RECOVER_HOLD     = 3'd4
    } cfg_reg_t;

    // Reset values of the timeout registers.
    localparam logic [TIME_W-1:0] ALARM_TIMEOUT_RST    = TIME_W'(1000);
    localparam logic [TIME_W-1:0] FAULT_TIMEOUT_RST    = TIME_W'(5000);
    localparam logic [TIME_W-1:0] RECOVERY_TIMEOUT_RST = TIME_W'(5000);
    localparam logic [TIME_W-1:0] RECOVER_HOLD_RST     = TIME_W'(5000);

    // Watchdog mode, one-hot.
    typedef enum logic [3:0] {
        MODE_NORMAL   = 4'b0001,
        MODE_ALARM    = 4'b0010,
        MODE_FAULT    = 4'b0100,
        MODE_RECOVERY = 4'b1000
    } mode_t;

    // Reported state codes.
    localparam logic [CODE_W-1:0] CODE_NORMAL   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ALARM    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_FAULT    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_RECOVERY = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DISABLED = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Map a mode to the code shown on the result channel.
    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        logic [CODE_W-1:0] c;
        case (m)
            MODE_ALARM:    c = CODE_ALARM;
            MODE_FAULT:    c = CODE_FAULT;
            MODE_RECOVERY: c = CODE_RECOVERY;
            default:       c = CODE_NORMAL;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/heartbeat_watchdog_fsm_core.sv */
// Heartbeat watchdog: tracks heartbeat changes per poll and steps a
// normal/alarm/fault/recovery state machine. Depends on hwd_pkg.
//
// An input transfer goes to the input register; the state update then
// writes the result register, which drives the result transfer.
// Throughput: one poll per cycle while m_tready holds; the state update is
// one pass of subtracts and compares, so a poll may follow in the next cycle.
// Reset (aresetn low, synchronous): registers to 0/1000/5000/5000/5000,
// state normal, stored times, spans and change count zero, channels empty.
`default_nettype none

module heartbeat_watchdog_fsm_core
    import hwd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    // Poll input.
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // tdata from bit 0: now_time, beat_value, beat_stamp.
    input  wire logic [S_DATA_W-1:0]   s_tdata,

    // Result output.
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // tdata from bit 0: watch_state, state_entered, recovery_elapsed,
    // worst_fault_recover, worst_alarm_recover, change_total, zero pad.
    output      logic [M_DATA_W-1:0]   m_tdata
);

    // Configuration registers.
    logic              watch_enable_reg;
    logic [TIME_W-1:0] alarm_timeout_reg;
    logic [TIME_W-1:0] fault_timeout_reg;
    logic [TIME_W-1:0] recovery_timeout_reg;
    logic [TIME_W-1:0] recover_hold_reg;

    // Configuration writes; indexes outside the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            watch_enable_reg     <= 1'b0;
            alarm_timeout_reg    <= ALARM_TIMEOUT_RST;
            fault_timeout_reg    <= FAULT_TIMEOUT_RST;
            recovery_timeout_reg <= RECOVERY_TIMEOUT_RST;
            recover_hold_reg     <= RECOVER_HOLD_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_WATCH_ENABLE:     watch_enable_reg     <= cfg_wdata[0];
                REG_ALARM_TIMEOUT:    alarm_timeout_reg    <= cfg_wdata[TIME_W-1:0];
                REG_FAULT_TIMEOUT:    fault_timeout_reg    <= cfg_wdata[TIME_W-1:0];
                REG_RECOVERY_TIMEOUT: recovery_timeout_reg <= cfg_wdata[TIME_W-1:0];
                REG_RECOVER_HOLD:     recover_hold_reg     <= cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: input stage and result stage.
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic [TIME_W-1:0] now_reg;
    logic [BEAT_W-1:0] beat_reg;
    logic [TIME_W-1:0] stamp_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input register: take a transfer whenever the stage is free.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            now_reg   <= s_tdata[TIME_W-1:0];
            beat_reg  <= s_tdata[TIME_W +: BEAT_W];
            stamp_reg <= s_tdata[TIME_W+BEAT_W +: TIME_W];
        end
    end

    // Watchdog state.
    mode_t              mode_reg,              mode_next;
    logic [BEAT_W-1:0]  held_value_reg,        held_value_next;
    logic [TIME_W-1:0]  change_time_reg,       change_time_next;
    logic [TIME_W-1:0]  prior_change_time_reg, prior_change_time_next;
    logic [COUNT_W-1:0] change_counter_reg,    change_counter_next;
    logic [TIME_W-1:0]  alarm_entry_reg,       alarm_entry_next;
    logic [TIME_W-1:0]  fault_entry_reg,       fault_entry_next;
    logic [TIME_W-1:0]  rec_start_reg,         rec_start_next;
    logic [TIME_W-1:0]  max_fault_span_reg,    max_fault_span_next;
    logic [TIME_W-1:0]  max_alarm_span_reg,    max_alarm_span_next;

    // Result fields for the poll in the input register.
    logic [CODE_W-1:0]  code_next;
    logic               entered_next;
    logic [TIME_W-1:0]  in_rec_next;

    // Per-poll differences, all wrapping at TIME_W bits.
    logic               changed;
    logic [TIME_W-1:0]  since;
    logic [TIME_W-1:0]  between;
    logic [TIME_W-1:0]  in_rec;
    logic [TIME_W-1:0]  fault_span;
    logic [TIME_W-1:0]  alarm_span;
    logic               to_alarm;
    logic               to_fault;
    logic               to_recovery;
    logic               to_normal;

    // Change detection and time differences; a disabled poll clears the history.
    always_comb begin
        changed = watch_enable_reg && (beat_reg != held_value_reg);
        if (!watch_enable_reg) begin
            held_value_next        = '0;
            change_time_next       = '0;
            prior_change_time_next = '0;
        end else begin
            held_value_next        = beat_reg;
            change_time_next       = changed ? stamp_reg : change_time_reg;
            prior_change_time_next = changed ? change_time_reg : prior_change_time_reg;
        end
        if (changed && change_counter_reg != COUNT_MAX) begin
            change_counter_next = change_counter_reg + COUNT_W'(1);
        end else begin
            change_counter_next = change_counter_reg;
        end
        since      = now_reg - change_time_next;
        between    = change_time_next - prior_change_time_next;
        in_rec     = now_reg - rec_start_reg;
        fault_span = now_reg - fault_entry_reg;
        alarm_span = now_reg - alarm_entry_reg;
    end

    // Transition conditions in priority order.
    always_comb begin
        to_alarm    = (mode_reg == MODE_NORMAL) && (since >= alarm_timeout_reg);
        to_fault    = ((mode_reg == MODE_ALARM) && (since >= fault_timeout_reg)) ||
                      ((mode_reg == MODE_RECOVERY) && (since >= recovery_timeout_reg));
        to_recovery = ((mode_reg == MODE_FAULT) || (mode_reg == MODE_ALARM)) &&
                      (since <= alarm_timeout_reg) && (between <= alarm_timeout_reg) &&
                      (change_counter_next > COUNT_W'(1));
        to_normal   = (mode_reg == MODE_RECOVERY) && (in_rec >= recover_hold_reg);
    end

    // Next state and result for the poll in the input register.
    always_comb begin
        mode_next           = mode_reg;
        alarm_entry_next    = alarm_entry_reg;
        fault_entry_next    = fault_entry_reg;
        rec_start_next      = rec_start_reg;
        max_fault_span_next = max_fault_span_reg;
        max_alarm_span_next = max_alarm_span_reg;
        entered_next        = 1'b0;
        in_rec_next         = in_rec;

        if (!watch_enable_reg) begin
            // Disabled poll: clear the entry times, force normal.
            alarm_entry_next = '0;
            fault_entry_next = '0;
            rec_start_next   = '0;
            mode_next        = MODE_NORMAL;
            in_rec_next      = '0;
            code_next        = CODE_DISABLED;
        end else begin
            if (to_alarm) begin
                mode_next        = MODE_ALARM;
                alarm_entry_next = now_reg;
                entered_next     = 1'b1;
            end else if (to_fault) begin
                mode_next        = MODE_FAULT;
                fault_entry_next = now_reg;
                entered_next     = 1'b1;
            end else if (to_recovery) begin
                if (mode_reg == MODE_FAULT && fault_span > max_fault_span_reg) begin
                    max_fault_span_next = fault_span;
                end
                if (mode_reg == MODE_ALARM && alarm_span > max_alarm_span_reg) begin
                    max_alarm_span_next = alarm_span;
                end
                rec_start_next = now_reg;
                mode_next      = MODE_RECOVERY;
                entered_next   = 1'b1;
            end else if (to_normal) begin
                mode_next    = MODE_NORMAL;
                entered_next = 1'b1;
            end
            code_next = mode_code(mode_next);
        end
    end

    // State update, one poll per advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg              <= MODE_NORMAL;
            held_value_reg        <= '0;
            change_time_reg       <= '0;
            prior_change_time_reg <= '0;
            change_counter_reg    <= '0;
            alarm_entry_reg       <= '0;
            fault_entry_reg       <= '0;
            rec_start_reg         <= '0;
            max_fault_span_reg    <= '0;
            max_alarm_span_reg    <= '0;
        end else if (advance) begin
            mode_reg              <= mode_next;
            held_value_reg        <= held_value_next;
            change_time_reg       <= change_time_next;
            prior_change_time_reg <= prior_change_time_next;
            change_counter_reg    <= change_counter_next;
            alarm_entry_reg       <= alarm_entry_next;
            fault_entry_reg       <= fault_entry_next;
            rec_start_reg         <= rec_start_next;
            max_fault_span_reg    <= max_fault_span_next;
            max_alarm_span_reg    <= max_alarm_span_next;
        end
    end

    // Result register.
    logic [CODE_W-1:0]  out_code_reg;
    logic               out_entered_reg;
    logic [TIME_W-1:0]  out_in_rec_reg;
    logic [TIME_W-1:0]  out_fault_reg;
    logic [TIME_W-1:0]  out_alarm_reg;
    logic [COUNT_W-1:0] out_count_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_code_reg    <= code_next;
            out_entered_reg <= entered_next;
            out_in_rec_reg  <= in_rec_next;
            out_fault_reg   <= max_fault_span_next;
            out_alarm_reg   <= max_alarm_span_next;
            out_count_reg   <= change_counter_next;
        end
    end

    assign m_tdata = {{(M_DATA_W - M_BITS){1'b0}}, out_count_reg, out_alarm_reg,
                      out_fault_reg, out_in_rec_reg, out_entered_reg, out_code_reg};

    // The worst spans and the change count never decrease.
    a_spans_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (max_fault_span_reg >= $past(max_fault_span_reg)) &&
                           (max_alarm_span_reg >= $past(max_alarm_span_reg)))
        else $error("worst span decreased");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> change_counter_reg >= $past(change_counter_reg))
        else $error("change count decreased");

    // A disabled poll never reports a transition and leaves the mode normal.
    a_disabled_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_code_reg == CODE_DISABLED) |->
            (!out_entered_reg && mode_reg == MODE_NORMAL && out_in_rec_reg == '0))
        else $error("disabled result inconsistent");

    // An enabled result shows the mode held after its poll.
    a_code_matches_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_code_reg != CODE_DISABLED) |->
            out_code_reg == mode_code(mode_reg))
        else $error("reported state differs from stored mode");

    // Entering recovery records the poll time as the recovery start.
    a_recovery_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && watch_enable_reg && to_recovery && !to_alarm && !to_fault) |=>
            rec_start_reg == $past(now_reg))
        else $error("recovery start time not recorded");

endmodule

`default_nettype wire

/* verif/heartbeat_watchdog_fsm_core_tb.sv */
// Self-checking testbench for heartbeat_watchdog_fsm_core: drives polls and register
// writes, predicts every result in place and compares it with the result stream.
// Depends on hwd_pkg and heartbeat_watchdog_fsm_core.

module heartbeat_watchdog_fsm_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hwd_pkg::*;

    // One result as it sits in m_tdata, lowest field last in this list.
    typedef struct packed {
        logic [COUNT_W-1:0] change_total;
        logic [TIME_W-1:0]  worst_alarm;
        logic [TIME_W-1:0]  worst_fault;
        logic [TIME_W-1:0]  rec_elapsed;
        logic               entered;
        logic [CODE_W-1:0]  state;
    } poll_report_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [M_DATA_W-1:0]   m_tdata;

    heartbeat_watchdog_fsm_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Watchdog shadow: configuration and state as the block should hold them.
    logic               watch_on;
    logic [TIME_W-1:0]  alarm_limit, fault_limit, recovery_limit, hold_limit;
    logic [CODE_W-1:0]  wd_state;
    logic [BEAT_W-1:0]  held_beat;
    logic [TIME_W-1:0]  change_t, prev_change_t;
    logic [TIME_W-1:0]  alarm_entry_t, fault_entry_t, rec_start_t;
    logic [TIME_W-1:0]  worst_fault, worst_alarm;
    logic [COUNT_W-1:0] change_count;

    poll_report_t pending_reports[$];
    int  fail_count      = 0;
    int  polls_sent      = 0;
    int  reports_checked = 0;
    int  transitions     = 0;
    int  stall_left      = 0;
    bit  no_idle         = 1'b0;

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Bring the shadow to its state after reset.
    task automatic reset_shadow();
        watch_on       = 1'b0;
        alarm_limit    = ALARM_TIMEOUT_RST;
        fault_limit    = FAULT_TIMEOUT_RST;
        recovery_limit = RECOVERY_TIMEOUT_RST;
        hold_limit     = RECOVER_HOLD_RST;
        wd_state       = CODE_NORMAL;
        held_beat      = '0;
        change_t       = '0;
        prev_change_t  = '0;
        alarm_entry_t  = '0;
        fault_entry_t  = '0;
        rec_start_t    = '0;
        worst_fault    = '0;
        worst_alarm    = '0;
        change_count   = '0;
    endtask

    // Advance the shadow by one poll and return the result it must produce.
    function automatic poll_report_t watchdog_predict(input logic [TIME_W-1:0] now_t,
                                                      input logic [BEAT_W-1:0] beat,
                                                      input logic [TIME_W-1:0] stamp);
        poll_report_t r;
        logic [TIME_W-1:0] since, between, in_rec, fspan, aspan;
        r = '0;
        if (!watch_on) begin
            // Disabled: forget the heartbeat history, keep count and worst spans.
            held_beat     = '0;
            change_t      = '0;
            prev_change_t = '0;
            alarm_entry_t = '0;
            fault_entry_t = '0;
            rec_start_t   = '0;
            wd_state      = CODE_NORMAL;
            r.state       = CODE_DISABLED;
        end else begin
            if (beat != held_beat) begin
                if (change_count != COUNT_MAX) begin
                    change_count = change_count + 1'b1;
                end
                prev_change_t = change_t;
                change_t      = stamp;
                held_beat     = beat;
            end
            since         = now_t - change_t;
            between       = change_t - prev_change_t;
            in_rec        = now_t - rec_start_t;
            r.rec_elapsed = in_rec;
            // At most one transition, highest priority first.
            if (wd_state == CODE_NORMAL && since >= alarm_limit) begin
                wd_state      = CODE_ALARM;
                alarm_entry_t = now_t;
                r.entered     = 1'b1;
            end else if ((wd_state == CODE_ALARM && since >= fault_limit) ||
                         (wd_state == CODE_RECOVERY && since >= recovery_limit)) begin
                wd_state      = CODE_FAULT;
                fault_entry_t = now_t;
                r.entered     = 1'b1;
            end else if ((wd_state == CODE_FAULT || wd_state == CODE_ALARM) &&
                         since <= alarm_limit && between <= alarm_limit &&
                         change_count > 1) begin
                fspan = now_t - fault_entry_t;
                aspan = now_t - alarm_entry_t;
                if (wd_state == CODE_FAULT && fspan > worst_fault) begin
                    worst_fault = fspan;
                end
                if (wd_state == CODE_ALARM && aspan > worst_alarm) begin
                    worst_alarm = aspan;
                end
                rec_start_t = now_t;
                wd_state    = CODE_RECOVERY;
                r.entered   = 1'b1;
            end else if (wd_state == CODE_RECOVERY && in_rec >= hold_limit) begin
                wd_state  = CODE_NORMAL;
                r.entered = 1'b1;
            end
            r.state = wd_state;
        end
        r.worst_fault  = worst_fault;
        r.worst_alarm  = worst_alarm;
        r.change_total = change_count;
        return r;
    endfunction

    // Stop sending and wait until every expected result has been transferred.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    // Write one register while the block is idle and mirror it in the shadow.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (addr)
            REG_WATCH_ENABLE:     watch_on       = value[0];
            REG_ALARM_TIMEOUT:    alarm_limit    = value;
            REG_FAULT_TIMEOUT:    fault_limit    = value;
            REG_RECOVERY_TIMEOUT: recovery_limit = value;
            REG_RECOVER_HOLD:     hold_limit     = value;
            default: ;
        endcase
    endtask

    // Send one poll after a random gap; predict its result once the transfer happens.
    task automatic send_poll(input logic [TIME_W-1:0] now_t,
                             input logic [BEAT_W-1:0] beat,
                             input logic [TIME_W-1:0] stamp);
        poll_report_t r;
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, beat, now_t};
        do @(posedge aclk); while (!s_tready);
        r = watchdog_predict(now_t, beat, stamp);
        pending_reports.push_back(r);
        polls_sent++;
        if (r.entered) begin
            transitions++;
        end
    endtask

    task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare one result transfer with the oldest expectation.
    task automatic check_report(input logic [M_DATA_W-1:0] data);
        poll_report_t got, want;
        got = data[M_BITS-1:0];
        if (pending_reports.size() == 0) begin
            $display("%0t ns: result with no poll waiting: expected none, actual %h",
                     $time, got);
            fail_count++;
        end else begin
            want = pending_reports.pop_front();
            compare_field("watch_state", TIME_W'(want.state), TIME_W'(got.state));
            compare_field("state_entered", TIME_W'(want.entered), TIME_W'(got.entered));
            compare_field("recovery_elapsed", want.rec_elapsed, got.rec_elapsed);
            compare_field("worst_fault_recover", want.worst_fault, got.worst_fault);
            compare_field("worst_alarm_recover", want.worst_alarm, got.worst_alarm);
            compare_field("change_total", TIME_W'(want.change_total),
                          TIME_W'(got.change_total));
        end
        reports_checked++;
    endtask

    // Result side: check each transfer, then hold tready low for a random stall.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_report(m_tdata);
                stall_left = no_idle ? 0 : $urandom_range(0, 9);
                if (stall_left != 0) begin
                    m_tready <= 1'b0;
                end
            end else if (!m_tready) begin
                stall_left--;
                if (stall_left <= 0) begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Polls while disabled, with every field at both extremes.
    task automatic test_disabled_polls();
        send_poll('1, '1, '1);
        send_poll('0, '0, '0);
    endtask

    // Walk every transition under the reset timeouts, including time wrap.
    task automatic test_state_walk();
        write_reg(REG_WATCH_ENABLE, 32'd1);
        send_poll(32'd100, 64'd0, 32'd0);
        send_poll(32'd1000, 64'd0, 32'd0);            // normal to alarm
        send_poll(32'd1500, 64'd5, 32'd1400);         // changes too far apart
        send_poll(32'd1600, 64'd6, 32'd1600);         // alarm to recovery
        send_poll(32'd6600, 64'd6, 32'd0);            // recovery to fault
        send_poll(32'd7000, 64'd7, 32'd6900);
        send_poll(32'd7100, 64'd8, 32'd7050);         // fault to recovery
        send_poll(32'd12100, 64'd9, 32'd12000);       // recovery to normal
        send_poll(32'd12200, 64'd9, 32'd12000);
        send_poll(32'hFFFF_FF00, 64'd9, 32'd0);       // alarm just before wrap
        send_poll(32'h0000_0010, 64'd10, 32'hFFFF_FFF0);
        send_poll(32'h0000_0020, 64'd11, 32'h0000_0018); // recovery across wrap
        send_poll('1, '1, '1);                        // hold elapsed, back to normal
        send_poll(32'h0000_1000, '1, 32'd0);          // normal to alarm
        send_poll(32'h0000_2000, '1, 32'd0);          // alarm to fault
    endtask

    // Unused register indexes are ignored; only bit 0 of the enable counts.
    task automatic test_register_decode();
        for (int a = REG_RECOVER_HOLD + 1; a < (1 << CFG_ADDR_W); a++) begin
            write_reg(a[CFG_ADDR_W-1:0], '0);
        end
        send_poll(32'h0000_2100, '1, 32'd0);
        write_reg(REG_WATCH_ENABLE, 32'hFFFF_FFFE);
        send_poll($urandom, {$urandom, $urandom}, $urandom);
        write_reg(REG_WATCH_ENABLE, 32'd1);
        send_poll(32'h0000_0400, 64'd3, 32'h0000_0300);
    endtask

    // Mostly plausible heartbeat streams with bursts and silences, some noise.
    task automatic run_traffic_phase(input int polls, input int unsigned step);
        logic [TIME_W-1:0] now_t;
        logic [BEAT_W-1:0] beat;
        bit beating;
        now_t   = ($urandom_range(0, 2) == 0) ? ('1 - $urandom_range(0, step * 50)) : $urandom;
        beat    = {$urandom, $urandom};
        beating = 1'b1;
        for (int k = 0; k < polls; k++) begin
            if ($urandom_range(0, 24) == 0) beating = !beating;
            if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
            if ($urandom_range(0, 149) == 0) drain_results();
            if ($urandom_range(0, 9) == 0) begin
                send_poll($urandom, {$urandom, $urandom}, $urandom);
            end else begin
                now_t = now_t + $urandom_range(0, step / 2 + 1);
                if (beating && $urandom_range(0, 9) < 7) begin
                    beat = $urandom_range(0, 1) ? {$urandom, $urandom} : beat + 1'b1;
                end
                send_poll(now_t, beat, now_t - $urandom_range(0, step / 4));
            end
        end
        no_idle = 1'b0;
    endtask

    // Phases with fresh settings: all zero, all ones, disabled, then random scales.
    task automatic test_random_traffic();
        int unsigned span, step;
        logic [CFG_DATA_W-1:0] en_val;
        for (int phase = 0; phase < 10; phase++) begin
            span   = $urandom_range(0, 1) ? $urandom_range(2, 60) : $urandom_range(60, 3000);
            en_val = {$urandom} | 32'h1;
            step   = span;
            if (phase == 2) begin
                en_val = {$urandom} & ~32'h1;
            end
            if (phase == 0) begin
                step = 8;
                write_reg(REG_ALARM_TIMEOUT, '0);
                write_reg(REG_FAULT_TIMEOUT, '0);
                write_reg(REG_RECOVERY_TIMEOUT, '0);
                write_reg(REG_RECOVER_HOLD, '0);
            end else if (phase == 1) begin
                step   = 1000;
                en_val = '1;
                write_reg(REG_ALARM_TIMEOUT, '1);
                write_reg(REG_FAULT_TIMEOUT, '1);
                write_reg(REG_RECOVERY_TIMEOUT, '1);
                write_reg(REG_RECOVER_HOLD, '1);
            end else begin
                write_reg(REG_ALARM_TIMEOUT, span);
                write_reg(REG_FAULT_TIMEOUT, span * $urandom_range(1, 4));
                write_reg(REG_RECOVERY_TIMEOUT, span * $urandom_range(1, 4));
                write_reg(REG_RECOVER_HOLD, span * $urandom_range(1, 4));
            end
            write_reg(REG_WATCH_ENABLE, en_val);
            no_idle = ($urandom_range(0, 3) == 0);
            run_traffic_phase(200, step);
        end
    endtask

    // A burst of back-to-back changes with no idle cycles on either side.
    task automatic test_change_burst();
        logic [BEAT_W-1:0] beat;
        write_reg(REG_WATCH_ENABLE, 32'd1);
        beat    = {$urandom, $urandom};
        no_idle = 1'b1;
        for (int k = 0; k < 64; k++) begin
            beat = ~beat;
            send_poll($urandom, beat, $urandom);
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    // Main sequence.
    initial begin
        int waited;
        reset_shadow();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_disabled_polls();
        test_state_walk();
        test_register_decode();
        test_random_traffic();
        test_change_burst();

        // Let the last results arrive, then allow for the pipeline latency.
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            $display("%0t ns: results missing: expected %0d more, actual 0",
                     $time, pending_reports.size());
            fail_count++;
        end

        $display("Run covered %0d polls with %0d state transitions over directed walks,",
                 polls_sent, transitions);
        $display("ten random setting phases and a burst of back-to-back changes; %0d checked.",
                 reports_checked);
        if (fail_count == 0) begin
            $display("heartbeat_watchdog_fsm_core_tb passed");
        end else begin
            $display("heartbeat_watchdog_fsm_core_tb failed");
        end
        $finish;
    end

    // Watchdog on the run itself.
    initial begin
        #20_000_000;
        $display("heartbeat_watchdog_fsm_core_tb failed");
        $finish;
    end

endmodule
